@@ hw/rtl/updatable_priority_task_table_top_assert.svh @@
// Assertion macros for the priority task table top level.
// No dependencies; included by the top level only.
`ifndef UPDATABLE_PRIORITY_TASK_TABLE_TOP_ASSERT_SVH
`define UPDATABLE_PRIORITY_TASK_TABLE_TOP_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define UPTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define UPTT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ hw/rtl/uptt_pkg.sv @@
// Types and constants shared by the priority task table modules.
// No dependencies.
package uptt_pkg;

  // Field widths of user ids, task ids and priorities.
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXEC   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [ID_BITS-1:0]   user_id;
    logic [ID_BITS-1:0]   task_id;
    logic [PRIO_BITS-1:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] top_user;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_APPLY,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the request, clear scan results
    logic scan_rd;  // present address to memories
    logic scan_eval;// evaluate registered read data
    logic apply;    // perform the write for the request
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_last;  // address counter on final entry
  } stat_t;

endpackage

@@ hw/rtl/uptt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module uptt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/uptt_ctrl.sv @@
// Controller for the priority task table: sequences a scan over all entries.
// Depends on uptt_pkg.
module uptt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output uptt_pkg::cmd_t cmd,
  input  uptt_pkg::stat_t stat
);

  uptt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uptt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      uptt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = uptt_pkg::S_SCAN;
        end
      end
      uptt_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.addr_last) begin
          state_next = uptt_pkg::S_LAST;
        end
      end
      uptt_pkg::S_LAST: begin
        cmd.scan_eval = 1'b1;
        state_next    = uptt_pkg::S_APPLY;
      end
      uptt_pkg::S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = uptt_pkg::S_OUT;
      end
      uptt_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = uptt_pkg::S_IDLE;
        end
      end
      default: state_next = uptt_pkg::S_IDLE;
    endcase
    // Read data of the previous address is evaluated while scanning.
    if (state == uptt_pkg::S_SCAN && !cmd.load) begin
      cmd.scan_eval = 1'b1;
    end
  end

endmodule

@@ hw/rtl/uptt_dp.sv @@
// Datapath for the priority task table: entry memories, valid bits,
// scan comparators and result register. Depends on uptt_pkg and uptt_ram.
module uptt_dp #(
  parameter int CAPACITY  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  uptt_pkg::in_beat_t in_data,
  output uptt_pkg::out_beat_t out_data,
  input  uptt_pkg::cmd_t     cmd,
  output uptt_pkg::stat_t    stat
);

  localparam int ID_BITS   = uptt_pkg::ID_BITS;
  localparam int PRIO_BITS = uptt_pkg::PRIO_BITS;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = ID_BITS + PRIO_BITS;

  logic [CAPACITY-1:0] valid;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       eval_addr;
  logic                eval_first;

  logic [1:0]           req_op;
  logic [ID_BITS-1:0]   req_user;
  logic [ID_BITS-1:0]   req_task;
  logic [PRIO_BITS-1:0] req_prio;

  logic               found;
  logic [AW-1:0]      found_idx;
  logic               free_ok;
  logic [AW-1:0]      free_idx;
  logic               best_ok;
  logic [AW-1:0]      best_idx;
  logic [CW-1:0]      best_key;
  logic [ID_BITS-1:0] best_user;

  logic [ID_BITS-1:0]   rd_task;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [ID_BITS-1:0]   rd_user;
  logic [CW-1:0]        rd_key;

  logic                 we_key;
  logic                 we_user;
  logic                 we_prio;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        add_idx;

  uptt_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_task (
    .clk(clk), .we(we_key), .waddr(waddr), .wdata(req_task),
    .raddr(addr), .rdata(rd_task)
  );
  uptt_ram #(.WIDTH(PRIO_BITS), .DEPTH(CAPACITY)) u_prio (
    .clk(clk), .we(we_prio), .waddr(waddr), .wdata(req_prio),
    .raddr(addr), .rdata(rd_prio)
  );
  // The user memory is scanned alongside the others so that the best
  // entry's user is known when the scan ends.
  uptt_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_user (
    .clk(clk), .we(we_user), .waddr(waddr), .wdata(req_user),
    .raddr(addr), .rdata(rd_user)
  );

  assign rd_key         = {rd_prio, rd_task};
  assign stat.addr_last = (addr == AW'(CAPACITY - 1));
  assign add_idx        = found ? found_idx : free_idx;

  always_comb begin
    we_key  = 1'b0;
    we_prio = 1'b0;
    we_user = 1'b0;
    waddr   = found_idx;
    if (cmd.apply) begin
      case (req_op)
        uptt_pkg::OP_ADD: begin
          waddr   = add_idx;
          we_key  = found || free_ok;
          we_prio = found || free_ok;
          we_user = found || free_ok;
        end
        uptt_pkg::OP_EDIT: we_prio = found;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op     <= in_data.op;
      req_user   <= in_data.user_id;
      req_task   <= in_data.task_id;
      req_prio   <= in_data.priority_req;
      addr       <= '0;
      eval_first <= 1'b1;
      found      <= 1'b0;
      free_ok    <= 1'b0;
      best_ok    <= 1'b0;
    end else if (cmd.scan_rd || cmd.scan_eval) begin
      if (cmd.scan_rd) begin
        addr      <= addr + AW'(1);
        eval_addr <= addr;
      end
      eval_first <= 1'b0;
      if (cmd.scan_eval && !eval_first) begin
        if (valid[eval_addr]) begin
          if (rd_task == req_task) begin
            found     <= 1'b1;
            found_idx <= eval_addr;
          end
          if (!best_ok || rd_key > best_key) begin
            best_ok   <= 1'b1;
            best_idx  <= eval_addr;
            best_key  <= rd_key;
            best_user <= rd_user;
          end
        end else if (!free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= eval_addr;
        end
      end
    end
  end

  // Valid bits and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.apply) begin
      case (req_op)
        uptt_pkg::OP_ADD: begin
          if (found || free_ok) valid[add_idx] <= 1'b1;
        end
        uptt_pkg::OP_REMOVE: begin
          if (found) valid[found_idx] <= 1'b0;
        end
        uptt_pkg::OP_EXEC: begin
          if (best_ok) valid[best_idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      case (req_op)
        uptt_pkg::OP_ADD: begin
          out_data.status   <= (found || free_ok) ? uptt_pkg::ST_OK : uptt_pkg::ST_FULL;
          out_data.top_user <= '0;
        end
        uptt_pkg::OP_EXEC: begin
          out_data.status   <= best_ok ? uptt_pkg::ST_OK : uptt_pkg::ST_EMPTY;
          out_data.top_user <= best_ok ? best_user : '0;
        end
        default: begin
          out_data.status   <= found ? uptt_pkg::ST_OK : uptt_pkg::ST_NOT_FOUND;
          out_data.top_user <= '0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/updatable_priority_task_table_top.sv @@
// Priority task table: one beat in, one result beat out per request.
// The input beat is taken in the idle state; the result is offered after a scan that
// reads the entries one by one, one last evaluation and one apply step.
// A new beat is taken only after the scan, the output state and the idle state have
// passed, so the block handles one request at a time; any output stall holds it off longer.
// Reset (rst, synchronous) clears all valid bits at once; no clearing pass.
module updatable_priority_task_table_top #(
  parameter int CAPACITY  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  uptt_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output uptt_pkg::out_beat_t out_data
);

  `include "updatable_priority_task_table_top_assert.svh"

  // Command and status between the controller and the datapath.
  uptt_pkg::cmd_t  cmd;
  uptt_pkg::stat_t stat;

  // The controller walks the scan and holds the result beat until taken.
  uptt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  // The datapath holds the entries and works out the result.
  uptt_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst),
    .in_data(in_data), .out_data(out_data),
    .cmd(cmd), .stat(stat)
  );

  // A beat is never taken while a result still waits.
  `UPTT_ASSERT(a_no_accept_with_result, !(out_valid && !in_stall), "accept while result pending")
  // Taking a beat always starts a scan.
  `UPTT_ASSERT_NEXT(a_accept_scans, in_valid && !in_stall, in_stall && !out_valid, "no scan after accept")
  // Apply is followed directly by a result beat.
  `UPTT_ASSERT_NEXT(a_apply_out, cmd.apply, out_valid, "no result after apply")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the updatable priority task table top level.
// Depends on uptt_pkg and updatable_priority_task_table_top only.
module tb;

  localparam int CAP = 64;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  uptt_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  uptt_pkg::out_beat_t out_data;

  // Predicted contents of the table, kept in the same slot order as the block.
  logic        slot_used [CAP];
  logic [15:0] slot_user [CAP];
  logic [15:0] slot_task [CAP];
  logic [15:0] slot_prio [CAP];

  uptt_pkg::out_beat_t pending_replies[$];
  int        errors = 0;
  int        beats_sent = 0;
  int        replies_seen = 0;
  int        full_seen = 0;
  int        empty_seen = 0;
  int        absent_seen = 0;
  int        exec_ok_seen = 0;
  bit        hold_receiver = 1'b0;
  bit        stall_pattern = 1'b1;

  updatable_priority_task_table_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Works out the reply to one request and updates the predicted table.
  function automatic uptt_pkg::out_beat_t table_apply(uptt_pkg::in_beat_t req);
    uptt_pkg::out_beat_t r;
    int hit;
    int slot;
    int best;
    r = '0;
    hit = -1;
    slot = -1;
    best = -1;
    for (int i = 0; i < CAP; i++) begin
      if (slot_used[i] && slot_task[i] == req.task_id && hit < 0) hit = i;
      if (!slot_used[i] && slot < 0) slot = i;
      if (slot_used[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
          (slot_prio[i] == slot_prio[best] && slot_task[i] > slot_task[best])))
        best = i;
    end
    case (uptt_pkg::op_t'(req.op))
      uptt_pkg::OP_ADD: begin
        if (hit < 0) hit = slot;
        if (hit < 0) begin
          r.status = uptt_pkg::ST_FULL;
        end else begin
          slot_used[hit] = 1'b1;
          slot_user[hit] = req.user_id;
          slot_task[hit] = req.task_id;
          slot_prio[hit] = req.priority_req;
        end
      end
      uptt_pkg::OP_EDIT: begin
        if (hit < 0) r.status = uptt_pkg::ST_NOT_FOUND;
        else slot_prio[hit] = req.priority_req;
      end
      uptt_pkg::OP_REMOVE: begin
        if (hit < 0) r.status = uptt_pkg::ST_NOT_FOUND;
        else slot_used[hit] = 1'b0;
      end
      default: begin
        if (best < 0) begin
          r.status = uptt_pkg::ST_EMPTY;
        end else begin
          r.top_user = slot_user[best];
          slot_used[best] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // Offers one beat, holds it until accepted, and queues its expected reply.
  task automatic send_request(uptt_pkg::op_t op, logic [15:0] uid, logic [15:0] tid,
                              logic [15:0] prio);
    uptt_pkg::in_beat_t req;
    req.op = op;
    req.user_id = uid;
    req.task_id = tid;
    req.priority_req = prio;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(table_apply(req));
    beats_sent++;
  endtask

  // Drops valid for a random gap now and then, so the sender idles in bursts.
  int burst_left = 0;
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    if ($urandom_range(0, 2) != 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Task ids are drawn from a narrow pool most of the time so that hits,
  // overwrites and misses all happen often.
  function automatic logic [15:0] pick_task_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 95)) ^ 16'hA500;
  endfunction

  // Boundary values of every field, each operation, and the empty, absent,
  // overwrite and priority-tie cases.
  task automatic test_directed();
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    send_request(uptt_pkg::OP_EDIT, 16'h0, 16'h0, 16'hFFFF);
    send_request(uptt_pkg::OP_REMOVE, 16'h0, 16'hFFFF, 16'h0);
    send_request(uptt_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(uptt_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000);
    send_request(uptt_pkg::OP_ADD, 16'h1234, 16'h0010, 16'h0100);
    send_request(uptt_pkg::OP_ADD, 16'h4321, 16'h0011, 16'h0100);
    send_request(uptt_pkg::OP_ADD, 16'h5555, 16'h0011, 16'h0100);
    send_request(uptt_pkg::OP_EDIT, 16'h0, 16'h0000, 16'hFFFF);
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    send_request(uptt_pkg::OP_REMOVE, 16'h0, 16'h0010, 16'h0);
    send_request(uptt_pkg::OP_REMOVE, 16'h0, 16'h0010, 16'h0);
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    send_request(uptt_pkg::OP_EXEC, 16'h0, 16'h0, 16'h0);
    wait_drained();
  endtask

  // Fills the table to the brim, tries to add past it, overwrites a present
  // task on the full table, then empties it again.
  task automatic test_full_table();
    for (int i = 0; i < CAP + 3; i++) begin
      send_request(uptt_pkg::OP_ADD, 16'($urandom), 16'(16'h2000 + i), 16'($urandom));
      sender_gap();
    end
    send_request(uptt_pkg::OP_ADD, 16'hBEEF, 16'h2005, 16'hFFFF);
    for (int i = 0; i < CAP + 1; i++) begin
      send_request(uptt_pkg::OP_EXEC, 16'($urandom), 16'($urandom), 16'($urandom));
      sender_gap();
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(uptt_pkg::op_t'($urandom_range(0, 3)), 16'($urandom), pick_task_id(),
                   16'($urandom));
    wait_drained();
  endtask

  // Mostly well-formed mixes of adds, edits, removes and executes on a
  // small id pool, with rare fully random beats.
  task automatic test_random_mix(int count);
    uptt_pkg::op_t op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = uptt_pkg::OP_ADD;
        4, 5: op = uptt_pkg::OP_EDIT;
        6: op = uptt_pkg::OP_REMOVE;
        default: op = uptt_pkg::OP_EXEC;
      endcase
      send_request(op, 16'($urandom), pick_task_id(), 16'($urandom_range(0, 3) == 0 ?
                   $urandom_range(0, 3) : $urandom));
      sender_gap();
      if (i % 400 == 399) wait_drained();
    end
    wait_drained();
  endtask

  // The receiver stall follows its own pattern: runs of stall-free cycles
  // alternate with random stalling, and one long hold-off on request.
  initial begin
    int hold_cycles;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 2000) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_receiver = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) stall_pattern = ~stall_pattern;
        out_stall <= stall_pattern ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
    end
  end

  // Compares each accepted reply with the oldest prediction.
  always @(posedge clk) begin
    uptt_pkg::out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data.status != want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.top_user != want.top_user) begin
          $display("%0t: top_user mismatch, expected %h, actual %h",
                   $time, want.top_user, out_data.top_user);
          errors++;
        end
        case (uptt_pkg::status_t'(want.status))
          uptt_pkg::ST_FULL: full_seen++;
          uptt_pkg::ST_EMPTY: empty_seen++;
          uptt_pkg::ST_NOT_FOUND: absent_seen++;
          default: if (want.top_user != 0 || out_data.top_user != 0) exec_ok_seen++;
        endcase
      end
    end
  end

  initial begin
    for (int i = 0; i < CAP; i++) begin
      slot_used[i] = 1'b0;
      slot_user[i] = '0;
      slot_task[i] = '0;
      slot_prio[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_mix(1490);
    // Let the pipeline settle in case anything is still on its way out.
    repeat (3 * (CAP + 4)) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      errors++;
    end
    $display("Sent %0d beats, checked %0d replies.", beats_sent, replies_seen);
    $display("Full %0d, empty %0d, not-found %0d, executes with a task %0d.",
             full_seen, empty_seen, absent_seen, exec_ok_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Worst case is roughly 1700 beats, each through a full scan, every reply stalled
  // and every gap at its longest, plus the long hold-off; this is well over.
  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/uptt_pkg.sv
hw/rtl/uptt_ram.sv
hw/rtl/uptt_ctrl.sv
hw/rtl/uptt_dp.sv
hw/rtl/updatable_priority_task_table_top.sv
bench/tb.sv
